[rtl/core/utf8_stream_decoder_top_macros.svh]
// assertion macros for the utf8 stream decoder
`ifndef UTF8_STREAM_DECODER_TOP_MACROS_SVH
`define UTF8_STREAM_DECODER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define UTF8SD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("utf8sd check failed");
`define UTF8SD_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("utf8sd check failed");
`else
`define UTF8SD_ASSERT(lbl, clk, rstn, prop)
`define UTF8SD_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/core/utf8sd_pkg.sv]
package utf8sd_pkg;

    localparam int CP_W    = 21;
    localparam int WIDTH_W = 3;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 3;
    localparam int MAX_RES = 4;

    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD4_LO = 8'hF0;
    localparam logic [7:0] LEAD4_HI = 8'hF4;
    localparam logic [1:0] CONT_TAG = 2'b10;

    localparam logic [CP_W-1:0] MIN_3B  = 21'h000800;
    localparam logic [CP_W-1:0] MIN_4B  = 21'h010000;
    localparam logic [CP_W-1:0] MAX_CP  = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;

    localparam logic [WIDTH_W-1:0] W_RAW = 3'd1;
    localparam logic [WIDTH_W-1:0] W_2B  = 3'd2;
    localparam logic [WIDTH_W-1:0] W_3B  = 3'd3;
    localparam logic [WIDTH_W-1:0] W_4B  = 3'd4;

    // results caused by one input byte
    typedef struct packed {
        logic [CNT_W-1:0]                 cnt;
        logic                             good;
        logic [WIDTH_W-1:0]               width;
        logic [CP_W-1:0]                  cp;
        logic [MAX_RES-1:0][BYTE_W-1:0]   raw;
    } t_bundle;

endpackage

[rtl/core/utf8sd_front.sv]
`include "utf8_stream_decoder_top_macros.svh"

module utf8sd_front
    import utf8sd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_eot,
    output logic              o_push,
    output t_bundle           o_bundle
);

    logic [BYTE_W-1:0]  r_lead, n_lead;
    logic [BYTE_W-1:0]  r_pend [2];
    logic [WIDTH_W-1:0] r_exp, n_exp;
    logic [1:0]         r_seen, n_seen;
    logic [CP_W-1:0]    r_partial, n_partial;

    logic                       is2, is3, is4, start_open, start_emit;
    logic                       seq_open, is_cont, complete, bad;
    logic                       do_close, do_start, pend_we;
    logic [CP_W-1:0]            v;
    logic [CNT_W-1:0]           got;
    logic [1:0]                 pos;
    logic [BYTE_W-1:0]          base [MAX_RES];
    t_bundle                    bnd;

    always_comb begin
        is2 = i_byte inside {[LEAD2_LO:LEAD2_HI]};
        is3 = i_byte inside {[LEAD3_LO:LEAD3_HI]};
        is4 = i_byte inside {[LEAD4_LO:LEAD4_HI]};
        start_open = (is2 | is3 | is4) & ~i_eot;
        start_emit = ~start_open;
        seq_open = r_exp inside {[W_2B:W_4B]};
        is_cont = (i_byte[7:6] == CONT_TAG);
        v = {r_partial[CP_W-7:0], i_byte[5:0]};
        got = CNT_W'(r_seen) + 3'd1;
        complete = (got + 3'd1) >= r_exp;
        bad = ((r_exp == W_3B) && (v < MIN_3B)) || ((r_exp == W_4B) && (v < MIN_4B)) ||
              (v > MAX_CP) || ((v >= SURR_LO) && (v <= SURR_HI));

        n_lead    = r_lead;
        n_exp     = r_exp;
        n_seen    = r_seen;
        n_partial = r_partial;
        do_close  = 1'b0;
        do_start  = 1'b0;
        pend_we   = 1'b0;
        pos       = r_seen + 2'd1;
        bnd.cnt   = '0;
        bnd.good  = 1'b0;
        bnd.width = r_exp;
        bnd.cp    = v;

        if (!seq_open) begin
            pos      = 2'd0;
            n_exp    = '0;
            bnd.cnt  = CNT_W'(start_emit);
            do_start = 1'b1;
        end else if (!is_cont) begin
            bnd.cnt  = CNT_W'(r_seen) + 3'd1 + CNT_W'(start_emit);
            do_close = 1'b1;
            do_start = 1'b1;
        end else if (complete) begin
            do_close = 1'b1;
            if (bad) begin
                bnd.cnt = got + 3'd1;
            end else begin
                bnd.cnt  = 3'd1;
                bnd.good = 1'b1;
            end
        end else if (i_eot) begin
            do_close = 1'b1;
            bnd.cnt  = got + 3'd1;
        end else begin
            pend_we   = 1'b1;
            n_seen    = got[1:0];
            n_partial = v;
        end

        if (do_close) begin
            n_lead    = '0;
            n_exp     = '0;
            n_seen    = '0;
            n_partial = '0;
        end
        if (do_start && start_open) begin
            n_lead = i_byte;
            n_seen = '0;
            if (is2) begin
                n_exp     = W_2B;
                n_partial = CP_W'(i_byte[4:0]);
            end else if (is3) begin
                n_exp     = W_3B;
                n_partial = CP_W'(i_byte[3:0]);
            end else begin
                n_exp     = W_4B;
                n_partial = CP_W'(i_byte[2:0]);
            end
        end

        // flush order: lead, buffered bytes, then the current byte
        base[0] = r_lead;
        base[1] = r_pend[0];
        base[2] = r_pend[1];
        base[3] = i_byte;
        for (int i = 0; i < MAX_RES; i++) begin
            bnd.raw[i] = (2'(i) == pos) ? i_byte : base[i];
        end
    end

    assign o_push   = i_accept && (bnd.cnt != '0);
    assign o_bundle = bnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead    <= '0;
            r_exp     <= '0;
            r_seen    <= '0;
            r_partial <= '0;
        end else if (i_accept) begin
            r_lead    <= n_lead;
            r_exp     <= n_exp;
            r_seen    <= n_seen;
            r_partial <= n_partial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && pend_we) begin
            r_pend[r_seen[0]] <= i_byte;
        end
    end

    `UTF8SD_ASSERT(a_exp_legal, i_clk, i_rst_n, r_exp == 3'd0 || r_exp == W_2B || r_exp == W_3B || r_exp == W_4B)
    `UTF8SD_ASSERT_IMPLY(a_seen_room, i_clk, i_rst_n, r_exp != 3'd0, (3'(r_seen) + 3'd2) <= r_exp)

endmodule

[rtl/core/utf8sd_queue.sv]
`include "utf8_stream_decoder_top_macros.svh"

module utf8sd_queue
    import utf8sd_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    input  logic    i_pop,
    output t_bundle o_head,
    output logic    o_empty,
    output logic    o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QW = $clog2(DEPTH + 1);

    t_bundle         r_slot [DEPTH];
    logic [PW-1:0]   r_wptr, r_rptr;
    logic [QW-1:0]   r_count;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_head  = r_slot[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= wrap_inc(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= wrap_inc(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_bundle;
        end
    end

    `UTF8SD_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= QW'(DEPTH))
    `UTF8SD_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full))

endmodule

[rtl/core/utf8sd_back.sv]
`include "utf8_stream_decoder_top_macros.svh"

module utf8sd_back
    import utf8sd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  t_bundle            i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [CP_W-1:0]    o_cp,
    output logic [WIDTH_W-1:0] o_width,
    output logic               o_last
);

    logic    r_valid;
    t_bundle r_bundle;
    logic [1:0] r_idx;
    logic    fire, last, load;

    assign last  = (CNT_W'(r_idx) + 3'd1) == r_bundle.cnt;
    assign fire  = r_valid && i_ready;
    assign load  = !r_valid || (fire && last);
    assign o_pop = load && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= !i_empty;
                r_idx   <= '0;
            end else if (fire) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bundle <= i_head;
        end
    end

    assign o_valid = r_valid;
    assign o_cp    = r_bundle.good ? r_bundle.cp : CP_W'(r_bundle.raw[r_idx]);
    assign o_width = r_bundle.good ? r_bundle.width : W_RAW;
    assign o_last  = last;

    `UTF8SD_ASSERT_IMPLY(a_idx_range, i_clk, i_rst_n, r_valid, 3'(r_idx) < r_bundle.cnt)
    `UTF8SD_ASSERT_IMPLY(a_good_single, i_clk, i_rst_n, r_valid && r_bundle.good, r_bundle.cnt == 3'd1)

endmodule

[rtl/core/utf8_stream_decoder_top.sv]
// utf8 stream decoder
// input channel (s): one raw text byte per item, tlast marks the final byte
// of the text. output channel (m): one code point per item with its width
// in bytes, tlast set on the last result caused by one input byte.
// bytes that cannot be decoded come out one by one as raw values, width 1.
// a front stage classifies each byte and builds the group of up to four
// results it causes; a queue of QUEUE_DEPTH groups feeds a back stage that
// sends them out one per cycle while the receiver is ready.
// a result is written into the queue and then loaded into the output
// register of the back stage before it is offered.
// throughput: one byte per cycle while each byte causes at most one result
// and the receiver is ready; a byte causing several results holds the
// output until all have left the single output register of the back stage.
// reset clears the open sequence, the queue and the output register.
// when the receiver stalls, the output item holds; the queue fills and then
// tready drops until room frees up.
module utf8_stream_decoder_top
    import utf8sd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // data_byte[7:0]
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // code_point[20:0], byte_width[23:21]
    output logic        o_m_tlast
);

    logic    accept, push, pop, q_empty, q_full;
    t_bundle f_bundle, q_head;
    logic [CP_W-1:0]    cp;
    logic [WIDTH_W-1:0] width;

    assign o_s_tready = !q_full;
    assign accept     = i_s_tvalid && !q_full;

    utf8sd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_tdata),
        .i_eot    (i_s_tlast),
        .o_push   (push),
        .o_bundle (f_bundle)
    );

    utf8sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (f_bundle),
        .i_pop    (pop),
        .o_head   (q_head),
        .o_empty  (q_empty),
        .o_full   (q_full)
    );

    utf8sd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (q_head),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_cp    (cp),
        .o_width (width),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = {width, cp};

endmodule

[dv/utf8_decode_checker.sv]
module utf8_decode_checker
    import utf8sd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // data_byte[7:0]
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // code_point[20:0], byte_width[23:21]
    input  logic        i_m_tlast,
    output int          o_mismatches,
    output int          o_waiting,
    output int          o_text_bytes,
    output int          o_results
);

    typedef struct packed {
        logic [CP_W-1:0]    cp;
        logic [WIDTH_W-1:0] width;
        logic               run_end;
    } t_cp_result;

    t_cp_result      expected_cps [$];
    logic [7:0]      lead_r;
    logic [7:0]      cont_buf [3];
    logic [2:0]      seq_len;
    logic [1:0]      cont_cnt;
    logic [CP_W-1:0] acc;
    int              step_results;
    int              mismatches = 0;
    int              text_bytes = 0;
    int              results = 0;

    assign o_mismatches = mismatches;
    assign o_waiting    = expected_cps.size();
    assign o_text_bytes = text_bytes;
    assign o_results    = results;

    task automatic emit(input logic [CP_W-1:0] cp, input logic [WIDTH_W-1:0] w);
        t_cp_result r;
        r.cp      = cp;
        r.width   = w;
        r.run_end = 1'b0;
        expected_cps.push_back(r);
        step_results++;
    endtask

    task automatic close_seq();
        lead_r   = 8'h00;
        seq_len  = 3'd0;
        cont_cnt = 2'd0;
        acc      = '0;
    endtask

    // lead and buffered continuation bytes go out raw
    task automatic flush_seq();
        emit(CP_W'(lead_r), W_RAW);
        for (int i = 0; i < cont_cnt; i++)
            emit(CP_W'(cont_buf[i]), W_RAW);
        close_seq();
    endtask

    task automatic start_lead(input logic [7:0] b, input logic eot);
        logic [2:0] len;
        logic [7:0] mask;
        len  = 3'd0;
        mask = 8'h00;
        if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            len  = W_2B;
            mask = 8'h1f;
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            len  = W_3B;
            mask = 8'h0f;
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            len  = W_4B;
            mask = 8'h07;
        end
        if (len == 3'd0 || eot) begin
            emit(CP_W'(b), W_RAW);
        end else begin
            lead_r   = b;
            seq_len  = len;
            cont_cnt = 2'd0;
            acc      = CP_W'(b & mask);
        end
    endtask

    task automatic decode_text_byte(input logic [7:0] b, input logic eot);
        logic [CP_W-1:0] v;
        logic [2:0]      got;
        logic            bad;
        t_cp_result      tail;
        step_results = 0;
        if (seq_len < W_2B || seq_len > W_4B) begin
            seq_len = 3'd0;
            start_lead(b, eot);
        end else if (b[7:6] != CONT_TAG) begin
            flush_seq();
            start_lead(b, eot);
        end else begin
            v   = {acc[CP_W-7:0], b[5:0]};
            got = {1'b0, cont_cnt} + 3'd1;
            if (got + 3'd1 >= seq_len) begin
                bad = (seq_len == W_3B && v < MIN_3B) || (seq_len == W_4B && v < MIN_4B) ||
                      v > MAX_CP || (v >= SURR_LO && v <= SURR_HI);
                if (bad) begin
                    flush_seq();
                    emit(CP_W'(b), W_RAW);
                end else begin
                    emit(v, seq_len);
                    close_seq();
                end
            end else if (eot) begin
                flush_seq();
                emit(CP_W'(b), W_RAW);
            end else begin
                cont_buf[cont_cnt] = b;
                cont_cnt           = got[1:0];
                acc                = v;
            end
        end
        if (step_results > 0) begin
            tail         = expected_cps.pop_back();
            tail.run_end = 1'b1;
            expected_cps.push_back(tail);
        end
    endtask

    task automatic check_field(input string name, input logic [CP_W-1:0] want,
                               input logic [CP_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_cp_result oldest;
        if (!i_rst_n) begin
            close_seq();
            expected_cps.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                results++;
                if (expected_cps.size() == 0) begin
                    $error("code_point: nothing expected, got 0x%0h", i_m_tdata[CP_W-1:0]);
                    mismatches++;
                end else begin
                    oldest = expected_cps.pop_front();
                    check_field("code_point", oldest.cp, i_m_tdata[CP_W-1:0]);
                    check_field("byte_width", CP_W'(oldest.width),
                                CP_W'(i_m_tdata[CP_W+WIDTH_W-1:CP_W]));
                    check_field("run_end", CP_W'(oldest.run_end), CP_W'(i_m_tlast));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                text_bytes++;
                decode_text_byte(i_s_tdata, i_s_tlast);
            end
        end
    end

endmodule

[dv/tb_top.sv]
module tb_top;
    import utf8sd_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        quiet_stretch = 1'b0;
    logic [7:0]  char_bytes [$];
    int          mismatches;
    int          waiting;
    int          text_bytes;
    int          results;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    utf8_stream_decoder_top i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    utf8_decode_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_mismatches (mismatches),
        .o_waiting    (waiting),
        .o_text_bytes (text_bytes),
        .o_results    (results)
    );

    always @(posedge clk) begin
        m_tready <= quiet_stretch || ($urandom_range(99) >= 28);
    end

    task automatic send_text_byte(input logic [7:0] b, input logic eot);
        while (!quiet_stretch && $urandom_range(99) < 28) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // one character: mostly well-formed encodings, some broken ones and noise
    task automatic make_random_char();
        int         kind;
        int         n;
        logic [20:0] cp;
        logic [7:0] lead;
        char_bytes.delete();
        kind = $urandom_range(99);
        if (kind < 15) begin
            char_bytes.push_back(8'($urandom_range(8'h7f, 8'h00)));
        end else if (kind < 35) begin
            cp = 21'($urandom_range(21'h7ff, 21'h080));
            char_bytes.push_back({3'b110, cp[10:6]});
            char_bytes.push_back({CONT_TAG, cp[5:0]});
        end else if (kind < 55) begin
            if ($urandom_range(1) == 0)
                cp = 21'($urandom_range(21'hd7ff, 21'h0800));
            else
                cp = 21'($urandom_range(21'hffff, 21'he000));
            char_bytes.push_back({4'b1110, cp[15:12]});
            char_bytes.push_back({CONT_TAG, cp[11:6]});
            char_bytes.push_back({CONT_TAG, cp[5:0]});
        end else if (kind < 70) begin
            cp = 21'($urandom_range(21'h10ffff, 21'h10000));
            char_bytes.push_back({5'b11110, cp[20:18]});
            char_bytes.push_back({CONT_TAG, cp[17:12]});
            char_bytes.push_back({CONT_TAG, cp[11:6]});
            char_bytes.push_back({CONT_TAG, cp[5:0]});
        end else if (kind < 85) begin
            case ($urandom_range(4))
                0: lead = LEAD3_LO;
                1: lead = 8'hed;
                2: lead = LEAD4_LO;
                3: lead = LEAD4_HI;
                default: begin
                    lead = 8'($urandom_range(LEAD4_HI, LEAD2_LO));
                end
            endcase
            char_bytes.push_back(lead);
            n = $urandom_range(3);
            repeat (n) begin
                if ($urandom_range(3) == 0)
                    char_bytes.push_back(8'($urandom));
                else
                    char_bytes.push_back({CONT_TAG, 6'($urandom)});
            end
        end else begin
            n = $urandom_range(3, 1);
            repeat (n) char_bytes.push_back(8'($urandom));
        end
    endtask

    initial begin
        logic [8:0] directed_text [25];
        int         sent;
        // eot flag in bit 8
        directed_text = '{9'h000, 9'h07f, 9'h080, 9'h0ff, 9'h0df, 9'h0bf, 9'h0e0, 9'h080,
                          9'h080, 9'h0ed, 9'h0a0, 9'h080, 9'h0f4, 9'h090, 9'h080, 9'h080,
                          9'h0f4, 9'h08f, 9'h0bf, 9'h0bf, 9'h0e2, 9'h041, 9'h0e2, 9'h182,
                          9'h1c3};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        foreach (directed_text[k])
            send_text_byte(directed_text[k][7:0], directed_text[k][8]);
        sent = 0;
        while (sent < 105) begin
            make_random_char();
            foreach (char_bytes[k]) begin
                quiet_stretch <= (sent >= 50 && sent < 90);
                send_text_byte(char_bytes[k], $urandom_range(15) == 0);
                sent++;
            end
        end
        s_tvalid      <= 1'b0;
        quiet_stretch <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        $display("covered %0d text bytes and %0d decoded results", text_bytes, results);
        $display("valid 1-4 byte forms, bad leads, overlong, surrogate, out of range, cut off");
        if (mismatches == 0)
            $display("utf8_stream_decoder_top: match");
        else
            $display("utf8_stream_decoder_top: mismatch");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("utf8_stream_decoder_top: mismatch");
        $finish;
    end

endmodule
